FILE: design/rcfd_pkg.sv
// Shared constants, types and channel decode function for the receiver frame decoder.
`timescale 1ns / 1ps
package rcfd_pkg;

    localparam int FRAME_BYTES_DEFAULT = 18;
    localparam int KEPT_BYTES          = 15;
    localparam int KEPT_IDX_W          = 4;
    localparam int RAW_W               = KEPT_BYTES * 8;
    localparam int QUEUE_DEPTH         = 2;

    localparam int CHAN_W   = 11;
    localparam int CENT_W   = 12;
    localparam int DBAND_W  = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND     = 1'd1;

    localparam logic [CHAN_W-1:0]  CENTER_OFFSET_RESET = 11'd1024;
    localparam logic [DBAND_W-1:0] DEAD_BAND_RESET     = 10'd12;

    localparam logic [1:0] SWITCH_LEFT_SAFE  = 2'd1;
    localparam logic [1:0] SWITCH_RIGHT_SAFE = 2'd3;
    localparam logic [1:0] SWITCH_INVALID    = 2'd0;

    typedef logic [RAW_W-1:0] raw_frame_t;

    // Frame handed from front to queue
    typedef struct packed {
        logic       valid;
        raw_frame_t raw;
    } frame_push_t;

    // Queue status seen by the back and the top-level input handshake
    typedef struct packed {
        logic full;
        logic nonempty;
    } queue_stat_t;

    typedef struct packed {
        logic signed [CENT_W-1:0] right_horizontal;
        logic signed [CENT_W-1:0] right_vertical;
        logic signed [CENT_W-1:0] left_horizontal;
        logic signed [CENT_W-1:0] left_vertical;
        logic [1:0]               switch_left;
        logic [1:0]               switch_right;
        logic signed [15:0]       mouse_dx;
        logic signed [15:0]       mouse_dy;
        logic signed [15:0]       mouse_dz;
        logic [15:0]              mouse_buttons;
        logic [7:0]               key_bits;
        logic                     frame_error;
    } record_t;

    // Centre a raw stick value and apply the deadband
    function automatic logic signed [CENT_W-1:0] centre_channel(
        input logic [CHAN_W-1:0]  raw,
        input logic [CHAN_W-1:0]  offset,
        input logic [DBAND_W-1:0] band
    );
        logic signed [CENT_W-1:0] v;
        logic signed [CENT_W:0]   v_ext;
        logic signed [CENT_W:0]   b_ext;
        v     = $signed({1'b0, raw}) - $signed({1'b0, offset});
        v_ext = {v[CENT_W-1], v};
        b_ext = $signed({3'b000, band});
        if (v_ext < b_ext && v_ext > -b_ext) begin
            v = '0;
        end
        return v;
    endfunction

endpackage

FILE: design/rcfd_front.sv
// Front end: tracks byte position, keeps frame bytes and pushes a complete raw frame.
`timescale 1ns / 1ps
module rcfd_front #(
    parameter int FRAME_BYTES = rcfd_pkg::FRAME_BYTES_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   byte_accept,
    input  logic [7:0]             frame_byte,
    input  logic                   frame_start,
    output rcfd_pkg::frame_push_t  push
);
    localparam int POS_W = $clog2(FRAME_BYTES + 1);
    localparam logic [POS_W-1:0] POS_IDLE = POS_W'(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_KEPT = POS_W'(rcfd_pkg::KEPT_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       store_reg [rcfd_pkg::KEPT_BYTES];
    logic [POS_W-1:0] pos_cur;
    logic [POS_W-1:0] pos_inc;
    logic             in_frame;
    logic             last_byte;
    rcfd_pkg::raw_frame_t raw_merged;

    assign pos_cur   = frame_start ? '0 : pos_reg;
    assign in_frame  = frame_start || (pos_reg < POS_IDLE);
    assign pos_inc   = pos_cur + POS_W'(1);
    assign last_byte = (pos_inc >= POS_IDLE);

    always_comb begin
        pos_next = pos_reg;
        if (byte_accept && in_frame) begin
            pos_next = last_byte ? POS_IDLE : pos_inc;
        end
    end

    // Current byte bypasses the store when it is itself one of the kept bytes
    always_comb begin
        for (int i = 0; i < rcfd_pkg::KEPT_BYTES; i++) begin
            raw_merged[i*8 +: 8] = (pos_cur == POS_W'(i)) ? frame_byte : store_reg[i];
        end
    end

    assign push.valid = byte_accept && in_frame && last_byte;
    assign push.raw   = raw_merged;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_IDLE;
        end else begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_accept && in_frame && (pos_cur < POS_KEPT)) begin
            store_reg[pos_cur[rcfd_pkg::KEPT_IDX_W-1:0]] <= frame_byte;
        end
    end

endmodule

FILE: design/rcfd_queue.sv
// Short queue of raw frames between front and back.
`timescale 1ns / 1ps
module rcfd_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rcfd_pkg::frame_push_t push,
    input  logic                  pop,
    output rcfd_pkg::raw_frame_t  head,
    output rcfd_pkg::queue_stat_t stat
);
    localparam int DEPTH = rcfd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rcfd_pkg::raw_frame_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign stat.full     = (count_reg == CNT_W'(DEPTH));
    assign stat.nonempty = (count_reg != '0);
    assign do_push       = push.valid && !stat.full;
    assign do_pop        = pop && stat.nonempty;
    assign head          = entry_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wptr_reg] <= push.raw;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.full |-> !push.valid)
        else $error("frame pushed into full queue");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count did not follow push");

endmodule

FILE: design/rcfd_back.sv
// Back end: decodes a queued raw frame into the output record register.
`timescale 1ns / 1ps
module rcfd_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rcfd_pkg::raw_frame_t                head,
    input  rcfd_pkg::queue_stat_t               stat,
    input  logic [rcfd_pkg::CHAN_W-1:0]         center_offset,
    input  logic [rcfd_pkg::DBAND_W-1:0]        dead_band,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output rcfd_pkg::record_t                   record
);
    logic              valid_reg, valid_next;
    rcfd_pkg::record_t record_reg;
    rcfd_pkg::record_t decoded;
    logic [1:0]        s1;
    logic [1:0]        s2;

    assign s1 = head[47:46];
    assign s2 = head[45:44];

    always_comb begin
        decoded = '0;
        if (s1 == rcfd_pkg::SWITCH_INVALID || s2 == rcfd_pkg::SWITCH_INVALID) begin
            decoded.switch_left  = rcfd_pkg::SWITCH_LEFT_SAFE;
            decoded.switch_right = rcfd_pkg::SWITCH_RIGHT_SAFE;
            decoded.frame_error  = 1'b1;
        end else begin
            // Four 11-bit channels packed back to back from bit 0
            decoded.right_horizontal =
                rcfd_pkg::centre_channel(head[10:0], center_offset, dead_band);
            decoded.right_vertical =
                rcfd_pkg::centre_channel(head[21:11], center_offset, dead_band);
            decoded.left_horizontal =
                rcfd_pkg::centre_channel(head[32:22], center_offset, dead_band);
            decoded.left_vertical =
                rcfd_pkg::centre_channel(head[43:33], center_offset, dead_band);
            decoded.switch_left   = s1;
            decoded.switch_right  = s2;
            decoded.mouse_dx      = head[63:48];
            decoded.mouse_dy      = head[79:64];
            decoded.mouse_dz      = head[95:80];
            decoded.mouse_buttons = head[111:96];
            decoded.key_bits      = head[119:112];
            decoded.frame_error   = 1'b0;
        end
    end

    assign pop = stat.nonempty && (!valid_reg || out_ready);

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            record_reg <= decoded;
        end
    end

    assign out_valid = valid_reg;
    assign record    = record_reg;

endmodule

FILE: design/rc_receiver_frame_decoder.sv
// Top level of the receiver frame decoder: config registers, front, queue and back.
// A frame is written into the queue when its last byte is taken; its record is then registered for m_tvalid.
// Throughput: one byte per cycle; s_tready drops only when both queue slots hold frames.
// The queue write and the output register set the latency; decode fits between them.
// Reset (aresetn low, synchronous): position goes idle, queue empties, output invalid,
// center_offset returns to 1024 and dead_band to 12. Frame bytes are not cleared.
`timescale 1ns / 1ps
module rc_receiver_frame_decoder #(
    parameter int FRAME_BYTES = rcfd_pkg::FRAME_BYTES_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Byte stream in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] frame_byte
    input  logic                                s_tuser,   // [0] frame_start
    // Decoded records out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [11:0] right_horizontal, [23:12] right_vertical, [35:24] left_horizontal,
    // [47:36] left_vertical, [49:48] switch_left, [51:50] switch_right,
    // [67:52] mouse_dx, [83:68] mouse_dy, [99:84] mouse_dz,
    // [115:100] mouse_buttons, [123:116] key_bits, [127:124] zero
    output logic [127:0]                        m_tdata,
    output logic                                m_tuser,   // [0] frame_error
    // Register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rcfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rcfd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    logic [rcfd_pkg::CHAN_W-1:0]  center_offset_reg;
    logic [rcfd_pkg::DBAND_W-1:0] dead_band_reg;
    logic                         cfg_write;
    logic                         byte_accept;

    rcfd_pkg::frame_push_t push;
    rcfd_pkg::raw_frame_t  head;
    rcfd_pkg::queue_stat_t stat;
    logic                  pop;
    rcfd_pkg::record_t     record;

    // Register writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_offset_reg <= rcfd_pkg::CENTER_OFFSET_RESET;
            dead_band_reg     <= rcfd_pkg::DEAD_BAND_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                rcfd_pkg::REG_CENTER_OFFSET: center_offset_reg <= cfg_data;
                rcfd_pkg::REG_DEAD_BAND:     dead_band_reg <= cfg_data[rcfd_pkg::DBAND_W-1:0];
                default: ;
            endcase
        end
    end

    // Bytes are taken whenever a queue slot is free, so a stalled output
    // only holds the input once two finished frames are waiting.
    assign s_tready    = !stat.full;
    assign byte_accept = s_tvalid && s_tready;

    rcfd_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .frame_byte  (s_tdata),
        .frame_start (s_tuser),
        .push        (push)
    );

    rcfd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .stat    (stat)
    );

    rcfd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .stat          (stat),
        .center_offset (center_offset_reg),
        .dead_band     (dead_band_reg),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .record        (record)
    );

    // Pack the record, first field in the low bits
    assign m_tdata = {4'b0000,
                      record.key_bits,
                      record.mouse_buttons,
                      record.mouse_dz,
                      record.mouse_dy,
                      record.mouse_dx,
                      record.switch_right,
                      record.switch_left,
                      record.left_vertical,
                      record.left_horizontal,
                      record.right_vertical,
                      record.right_horizontal};
    assign m_tuser = record.frame_error;

endmodule
